/* hdl/mau_pkg.sv */
// mau_pkg: shared types and constants of the modular arithmetic unit
// action codes, sequencer states and the reducer request bundle
// no dependencies
`default_nettype none

package mau_pkg;

  // width of the bit stream fed to the reducer and of its bit counter
  localparam int unsigned VAL_W = 64;
  localparam int unsigned CNT_W = 7;

  // modulus after reset, before any masking to the residue width
  localparam logic [30:0] MOD_RESET = 31'd998244353;

  typedef enum logic [2:0] {
    ACT_REDUCE = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_NEG    = 3'd4,
    ACT_POW    = 3'd5,
    ACT_INV    = 3'd6,
    ACT_DIV    = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_EXEC,
    ST_POW_TEST,
    ST_MUL,
    ST_MRED,
    ST_MWAIT,
    ST_FINISH
  } state_t;

  // where a reduced product goes
  typedef enum logic [1:0] {
    D_ACC,
    D_BASE,
    D_RES
  } dest_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } red_req_t;

endpackage

`default_nettype wire

/* hdl/mau_reducer.sv */
// mau_reducer: bit-serial remainder of a left-aligned value modulo m
// one shift and one compare-subtract per cycle
// depends on mau_pkg
`default_nettype none

module mau_reducer #(
  parameter int unsigned RW = 31
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mau_pkg::red_req_t         req,
  input  wire logic [mau_pkg::VAL_W-1:0] val,
  input  wire logic [RW-1:0]             m,
  output logic                           done,
  output logic [RW-1:0]                  rem
);
  import mau_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] sreg;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic [RW-1:0]    rem_next;

  // shift the next bit in, then one conditional subtract keeps rem below m
  always_comb begin
    trial = {rem, sreg[VAL_W-1]};
    diff  = trial - {1'b0, m};
    if (trial >= {1'b0, m}) begin
      rem_next = diff[RW-1:0];
    end else begin
      rem_next = trial[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sreg <= val;
      rem  <= '0;
    end else if (busy) begin
      sreg <= {sreg[VAL_W-2:0], 1'b0};
      rem  <= rem_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/modular_arithmetic_unit.sv */
// modular_arithmetic_unit: top level, sequencer, shared multiplier, output register
// instantiates mau_reducer, uses mau_pkg
// reduce, add, sub, mul, neg, pow, inv (fermat) and div over a configured modulus
`default_nettype none

// channel   direction  handshake               payload
// in        in         in_valid / in_stall     action, operand_a, operand_b
// out       out        out_valid / out_stall   result
// cfg       in         cfg_valid / cfg_ready   modulus
//
// one request at a time; in_stall is high from acceptance until the result is
// loaded into the output register (a waiting result does not block a new request)
// the time per request is set by the bit-serial reducer: it reduces operand_a after
// acceptance, then operand_b where the action uses it, then the product of each modular
// multiply (W = residue width); pow/inv/div use up to two multiplies per exponent bit
// rst is synchronous; it restores the modulus to 998244353 (masked to W bits)

module modular_arithmetic_unit #(
  parameter int unsigned RESIDUE_WIDTH = 31
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [63:0] operand_a,
  input  wire logic [62:0] operand_b,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      result,
  // modulus write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [30:0] modulus
);
  import mau_pkg::*;

  // effective residue width: the modulus field itself is 31 bits
  localparam int unsigned RW = (RESIDUE_WIDTH < 31) ? RESIDUE_WIDTH : 31;
  localparam int unsigned PW = 2 * RW;

  state_t        state;
  state_t        state_next;
  action_t       act;
  dest_t         dest;
  logic [RW-1:0] mod_q;
  logic          a_neg;
  logic [62:0]   b_raw;
  logic [RW-1:0] a_res;
  logic [RW-1:0] b_res;
  logic [RW-1:0] res;
  logic [RW-1:0] acc;
  logic [RW-1:0] base;
  logic [62:0]   expo;
  logic [RW-1:0] mul_x;
  logic [RW-1:0] mul_y;
  logic [PW-1:0] prod;

  red_req_t         red_req;
  logic [VAL_W-1:0] red_val;
  logic             red_done;
  logic [RW-1:0]    red_rem;

  logic             mod_small;
  logic             needs_b;
  logic [63:0]      a_mag;
  logic [RW:0]      add_sum;
  logic [RW:0]      add_red;
  logic [RW:0]      sub_val;
  logic             out_free;

  mau_reducer #(
    .RW (RW)
  ) u_reducer (
    .clk  (clk),
    .rst  (rst),
    .req  (red_req),
    .val  (red_val),
    .m    (mod_q),
    .done (red_done),
    .rem  (red_rem)
  );

  assign cfg_ready = 1'b1;
  assign mod_small = (mod_q < RW'(2));
  assign needs_b   = (act == ACT_ADD) || (act == ACT_SUB) ||
                     (act == ACT_MUL) || (act == ACT_DIV);
  // magnitude of the signed operand; the most negative value maps to 2^63
  assign a_mag     = operand_a[63] ? (~operand_a + 64'd1) : operand_a;
  assign out_free  = !out_valid || !out_stall;

  // add and sub on residues, one correction each
  always_comb begin
    add_sum = {1'b0, a_res} + {1'b0, b_res};
    add_red = add_sum - {1'b0, mod_q};
    if (a_res >= b_res) begin
      sub_val = {1'b0, a_res} - {1'b0, b_res};
    end else begin
      sub_val = {1'b0, a_res} + {1'b0, mod_q} - {1'b0, b_res};
    end
  end

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_q <= MOD_RESET[RW-1:0];
    end else if (cfg_valid && cfg_ready) begin
      mod_q <= modulus[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = mod_small ? ST_FINISH : ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (red_done) begin
          state_next = needs_b ? ST_RED_B : ST_EXEC;
        end
      end
      ST_RED_B: begin
        if (red_done) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (act)
          ACT_MUL: state_next = ST_MUL;
          ACT_POW: state_next = ST_POW_TEST;
          ACT_INV: state_next = (a_res == '0) ? ST_FINISH : ST_POW_TEST;
          ACT_DIV: state_next = (b_res == '0) ? ST_FINISH : ST_POW_TEST;
          default: state_next = ST_FINISH;
        endcase
      end
      ST_POW_TEST: begin
        if (expo == '0) begin
          state_next = (act == ACT_DIV) ? ST_MUL : ST_FINISH;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_MRED;
      ST_MRED: state_next = ST_MWAIT;
      ST_MWAIT: begin
        if (red_done) begin
          unique case (dest)
            D_ACC:   state_next = (expo[62:1] == '0) ? ST_POW_TEST : ST_MUL;
            D_BASE:  state_next = ST_POW_TEST;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: request stall and reducer requests
  always_comb begin
    in_stall      = (state != ST_IDLE);
    red_req.start = 1'b0;
    red_req.nbits = CNT_W'(VAL_W);
    red_val       = a_mag;
    unique case (state)
      ST_IDLE: begin
        red_req.start = in_valid && !mod_small;
      end
      ST_RED_A: begin
        // operand_b is left aligned: 63 bits then a pad bit
        red_req.start = red_done && needs_b;
        red_req.nbits = CNT_W'(63);
        red_val       = {b_raw, 1'b0};
      end
      ST_MRED: begin
        red_req.start = 1'b1;
        red_req.nbits = CNT_W'(PW);
        red_val       = {prod, {(VAL_W - PW){1'b0}}};
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          act   <= action_t'(action);
          a_neg <= operand_a[63];
          b_raw <= operand_b;
          res   <= '0;
        end
      end
      ST_RED_A: begin
        if (red_done) begin
          if (a_neg && (red_rem != '0)) begin
            a_res <= mod_q - red_rem;
          end else begin
            a_res <= red_rem;
          end
        end
      end
      ST_RED_B: begin
        if (red_done) begin
          b_res <= red_rem;
        end
      end
      ST_EXEC: begin
        acc <= RW'(1);
        unique case (act)
          ACT_REDUCE: res <= a_res;
          ACT_ADD: begin
            if (add_sum >= {1'b0, mod_q}) begin
              res <= add_red[RW-1:0];
            end else begin
              res <= add_sum[RW-1:0];
            end
          end
          ACT_SUB: res <= sub_val[RW-1:0];
          ACT_MUL: begin
            mul_x <= a_res;
            mul_y <= b_res;
            dest  <= D_RES;
          end
          ACT_NEG: res <= (a_res == '0) ? '0 : (mod_q - a_res);
          ACT_POW: begin
            base <= a_res;
            expo <= b_raw;
          end
          ACT_INV: begin
            res  <= '0;
            base <= a_res;
            expo <= 63'(mod_q - RW'(2));
          end
          default: begin
            // divide: invert b first, then multiply by a
            res  <= '0;
            base <= b_res;
            expo <= 63'(mod_q - RW'(2));
          end
        endcase
      end
      ST_POW_TEST: begin
        if (expo == '0) begin
          res   <= acc;
          mul_x <= a_res;
          mul_y <= acc;
          dest  <= D_RES;
        end else if (expo[0]) begin
          mul_x <= acc;
          mul_y <= base;
          dest  <= D_ACC;
        end else begin
          mul_x <= base;
          mul_y <= base;
          dest  <= D_BASE;
        end
      end
      ST_MUL: begin
        prod <= {{RW{1'b0}}, mul_x} * {{RW{1'b0}}, mul_y};
      end
      ST_MWAIT: begin
        if (red_done) begin
          unique case (dest)
            D_ACC: begin
              acc <= red_rem;
              if (expo[62:1] == '0) begin
                // last exponent bit: the final squaring is not needed
                expo <= '0;
              end else begin
                mul_x <= base;
                mul_y <= base;
                dest  <= D_BASE;
              end
            end
            D_BASE: begin
              base <= red_rem;
              expo <= {1'b0, expo[62:1]};
            end
            default: res <= red_rem;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      result <= 31'(res);
    end
  end

endmodule

`default_nettype wire
